>>> rtl/stfo_pkg.sv
// Package for the lamp sleep timer with fade-out.
// Holds field widths, operation and alert codes, register indexes, the sequencer state
// type, the status struct shared by the top level and the divider, and the result struct.
`default_nettype none

package stfo_pkg;

    // Field widths of the item channels and the configuration port.
    localparam int OP_W       = 3;
    localparam int NOW_W      = 40;
    localparam int ARG_W      = 32;
    localparam int LEVEL_W    = 16;
    localparam int PROG_W     = 16;
    localparam int ALERT_W    = 2;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register widths.
    localparam int RAMP_W     = 12;
    localparam int MAXADD_W   = 8;
    localparam int LOOP_W     = 10;
    localparam int CALLS_W    = 10;

    // Internal datapath widths.
    localparam int DEADLINE_W = 32;
    localparam int NOW_S_W    = 31;
    localparam int RMS_W      = 22;
    localparam int TARGET_W   = 42;
    localparam int ADD_W      = 14;
    localparam int WIN_W      = 7;
    localparam int DIV_W      = 40;
    localparam int DVS_W      = 22;
    localparam int DIV_CNT_W  = 6;

    // Constants of the timer arithmetic.
    localparam logic [RMS_W-1:0]   MS_PER_S      = 22'd1000;
    localparam logic [RMS_W-1:0]   SEC_PER_MIN   = 22'd60;
    localparam logic [RMS_W-1:0]   HALF_MIN      = 22'd30;
    localparam logic [RMS_W-1:0]   IDLE_DELAY_MS = 22'd100;
    localparam logic [PROG_W-1:0]  PROG_DONE     = 16'hFFFF;
    localparam logic [DELAY_W-1:0] DELAY_MAX     = 16'hFFFF;

    // Event codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_SET    = 3'd1,
        OP_ADD    = 3'd2,
        OP_SHORT  = 3'd3,
        OP_BUMP   = 3'd4,
        OP_CANCEL = 3'd5,
        OP_LOCK   = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXADD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CALLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL   = 3'd5;

    // Alert event codes.
    localparam logic [ALERT_W-1:0] ALERT_NONE  = 2'd0;
    localparam logic [ALERT_W-1:0] ALERT_RAISE = 2'd1;
    localparam logic [ALERT_W-1:0] ALERT_CLEAR = 2'd2;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_WAIT,
        ST_NS_DONE,
        ST_R_DONE,
        ST_CAP_DONE,
        ST_OP,
        ST_BUMP_W,
        ST_BUMP_D,
        ST_ADD,
        ST_SET,
        ST_PROG,
        ST_PROG2,
        ST_P_DONE,
        ST_LEVEL,
        ST_L_DONE,
        ST_FIN
    } state_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // One result item.
    typedef struct packed {
        logic                 level_valid;
        logic [LEVEL_W-1:0]   level_limit;
        logic                 progress_valid;
        logic [PROG_W-1:0]    progress_q16;
        logic                 power_off;
        logic [ALERT_W-1:0]   alert_event;
        logic                 timer_on;
        logic [DELAY_W-1:0]   tick_delay_ms;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/stfo_if.sv
// Channel interfaces of the sleep timer: event items, result items and
// configuration writes. Depends on stfo_pkg for the field widths.
`default_nettype none

// Event item channel.
interface stfo_evt_if;
    import stfo_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [NOW_W-1:0] now_ms;
    logic [ARG_W-1:0] arg_value;

    modport source (output valid, output op, output now_ms, output arg_value, input ready);
    modport sink   (input valid, input op, input now_ms, input arg_value, output ready);
endinterface

// Result item channel.
interface stfo_res_if;
    import stfo_pkg::*;

    logic               valid;
    logic               ready;
    logic               level_valid;
    logic [LEVEL_W-1:0] level_limit;
    logic               progress_valid;
    logic [PROG_W-1:0]  progress_q16;
    logic               power_off;
    logic [ALERT_W-1:0] alert_event;
    logic               timer_on;
    logic [DELAY_W-1:0] tick_delay_ms;

    modport source (
        output valid, output level_valid, output level_limit, output progress_valid,
        output progress_q16, output power_off, output alert_event, output timer_on,
        output tick_delay_ms, input ready
    );
    modport sink (
        input valid, input level_valid, input level_limit, input progress_valid,
        input progress_q16, input power_off, input alert_event, input timer_on,
        input tick_delay_ms, output ready
    );
endinterface

// Configuration write channel.
interface stfo_cfg_if;
    import stfo_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

>>> rtl/stfo_div.sv
// Shared restoring divider of the sleep timer, one quotient bit per cycle.
// Depends on stfo_pkg for the operand widths and the status struct.
`default_nettype none

module stfo_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [stfo_pkg::DIV_W-1:0]  dividend,
    input  wire logic [stfo_pkg::DVS_W-1:0]  divisor,
    output stfo_pkg::div_stat_t              stat,
    output logic [stfo_pkg::DIV_W-1:0]       quotient
);
    import stfo_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 fits;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Next values of the control and the datapath.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/sleep_timer_with_fade_out.sv
// Sleep timer with brightness fade-out: a sequencer around one shared serial divider.
// Depends on stfo_pkg, the channel interfaces in stfo_if.sv and the divider stfo_div.
//
// The block keeps a lamp's shutdown deadline in seconds and a fade enable. Each event
// item (tick, set deadline, add minutes, shortcut, bump, cancel, lock) gives exactly one
// result item with the new brightness limit, fade progress in Q0.16, power-off, alert
// change, timer state and the next tick period. All divisions go through one 40-step
// restoring divider, one quotient at a time; an item needs one to six of them: one
// for a simple event with saved level zero, up to six for a bump that reschedules
// a running timer. The event channel is ready
// only while the sequencer is idle; the result sits in an output register, so the next
// event is taken while a finished result still waits to be read.
`default_nettype none

module sleep_timer_with_fade_out (
    input  wire logic  clk,
    input  wire logic  rst_n,
    stfo_evt_if.sink   event_ch,
    stfo_res_if.source result_ch,
    stfo_cfg_if.sink   cfg_ch
);
    import stfo_pkg::*;

    // Configuration registers.
    logic [RAMP_W-1:0]   ramp_reg;
    logic [MAXADD_W-1:0] maxadd_reg;
    logic [LOOP_W-1:0]   loop_reg;
    logic [CALLS_W-1:0]  calls_reg;
    logic [LEVEL_W-1:0]  saved_reg;
    logic [LEVEL_W-1:0]  full_reg;

    // Timer state and sequencer control.
    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    logic [DEADLINE_W-1:0] deadline_reg, deadline_next;
    logic                  fade_reg, fade_next;
    logic                  out_valid_reg, out_valid_next;

    // Item working registers.
    op_t                   op_reg, op_next;
    logic [NOW_W-1:0]      now_ms_reg, now_ms_next;
    logic [ARG_W-1:0]      arg_reg, arg_next;
    logic [RAMP_W-1:0]     rs_reg, rs_next;
    logic [RMS_W-1:0]      rms_reg, rms_next;
    logic [NOW_S_W-1:0]    now_s_reg, now_s_next;
    logic [RMS_W-1:0]      period_reg, period_next;
    logic [RMS_W-1:0]      r_reg, r_next;
    logic [DEADLINE_W-1:0] t_reg, t_next;
    logic [ARG_W-1:0]      m_reg, m_next;
    logic [WIN_W-1:0]      w_reg, w_next;
    logic [TARGET_W-1:0]   target_reg, target_next;
    logic [RMS_W-1:0]      rem_reg, rem_next;

    // Result fields under construction and the output register.
    logic                  lv_reg, lv_next;
    logic [LEVEL_W-1:0]    lim_reg, lim_next;
    logic                  pv_reg, pv_next;
    logic [PROG_W-1:0]     prog_reg, prog_next;
    logic                  poff_reg, poff_next;
    logic [ALERT_W-1:0]    alert_reg, alert_next;
    res_t                  out_reg, out_next;

    // Divider connection.
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    state_t                div_ret;
    div_stat_t             div_stat;
    logic [DIV_W-1:0]      div_quo;

    // Shared conditions and arithmetic.
    logic                  accept;
    logic                  out_free;
    logic [CALLS_W-1:0]    calls_eff;
    logic [RMS_W-1:0]      r_plus;
    logic                  r_le_loop;
    logic [DEADLINE_W-1:0] now_s32;
    logic [DEADLINE_W:0]   nsr_sum;
    logic                  dl_nz;
    logic                  tick_hit;
    logic                  short_hit;
    logic                  dl_past;
    logic [NOW_W:0]        used;
    logic                  prog_fin;
    logic [TARGET_W-1:0]   rem_full;
    logic                  rem_clamp;
    logic [RMS_W-1:0]      x_val;
    logic [RMS_W+LEVEL_W-1:0] pnum;
    logic [RMS_W+LEVEL_W-1:0] lvl_num;
    logic [MAXADD_W-1:0]   m_cap;
    logic [ADD_W-1:0]      add_s;
    logic [DEADLINE_W-1:0] base;
    logic [DEADLINE_W:0]   sum_t;
    logic [DEADLINE_W-1:0] t_sat;
    logic [DEADLINE_W:0]   bump_num;
    logic                  d_le_w;
    logic                  t_le_now;
    logic                  is_tick;

    assign accept   = event_ch.valid && event_ch.ready;
    assign out_free = !out_valid_reg || result_ch.ready;

    assign event_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready   = 1'b1;

    // Period terms: a zero call count acts as one.
    assign calls_eff = (calls_reg == '0) ? CALLS_W'(1) : calls_reg;
    assign r_plus    = div_quo[RMS_W-1:0] + RMS_W'(1);
    assign r_le_loop = r_plus <= RMS_W'(loop_reg);

    // Deadline comparisons against the current second.
    assign now_s32   = {1'b0, now_s_reg};
    assign nsr_sum   = {1'b0, now_s32} + (DEADLINE_W+1)'(rs_reg);
    assign dl_nz     = deadline_reg != '0;
    assign tick_hit  = dl_nz && (nsr_sum >= {1'b0, deadline_reg});
    assign short_hit = dl_nz && ({1'b0, deadline_reg} > nsr_sum);
    assign dl_past   = deadline_reg < now_s32;
    assign t_le_now  = t_reg <= now_s32;
    assign is_tick   = (op_reg == OP_TICK);

    // Progress: time left before the finish line, clamped to the ramp.
    assign used      = (NOW_W+1)'(period_reg) + {1'b0, now_ms_reg};
    assign prog_fin  = (now_s32 >= deadline_reg) || (target_reg <= TARGET_W'(used));
    assign rem_full  = target_reg - TARGET_W'(used);
    assign rem_clamp = rem_full >= TARGET_W'(rms_reg);
    assign x_val     = rms_reg - rem_full[RMS_W-1:0];
    assign pnum      = {x_val, LEVEL_W'(0)} - (RMS_W+LEVEL_W)'(x_val);
    assign lvl_num   = (RMS_W+LEVEL_W)'(saved_reg) * (RMS_W+LEVEL_W)'(rem_reg);

    // Add minutes: capped amount on top of a running deadline or the current second.
    assign m_cap = (m_reg < ARG_W'(maxadd_reg)) ? m_reg[MAXADD_W-1:0] : maxadd_reg;
    assign add_s = ADD_W'(m_cap) * ADD_W'(SEC_PER_MIN);
    assign base  = (dl_nz && !dl_past && (deadline_reg != now_s32)) ? deadline_reg : now_s32;
    assign sum_t = {1'b0, base} + (DEADLINE_W+1)'(add_s);
    assign t_sat = sum_t[DEADLINE_W] ? '1 : sum_t[DEADLINE_W-1:0];

    // Bump: minutes left, rounded half up.
    assign bump_num = {1'b0, deadline_reg} - {2'b0, now_s_reg} + (DEADLINE_W+1)'(HALF_MIN);
    assign d_le_w   = div_quo <= DIV_W'(w_reg);

    // Divider issue: operands and the state that takes the quotient.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = MS_PER_S;
        div_ret      = ST_IDLE;
        unique case (state_reg)
            ST_PREP:
            begin
                div_start    = 1'b1;
                div_dividend = now_ms_reg;
                div_divisor  = MS_PER_S;
                div_ret      = ST_NS_DONE;
            end
            ST_NS_DONE:
            begin
                div_start    = saved_reg != '0;
                div_dividend = DIV_W'(rms_reg);
                div_divisor  = DVS_W'(saved_reg);
                div_ret      = ST_R_DONE;
            end
            ST_R_DONE:
            begin
                div_start    = !r_le_loop;
                div_dividend = DIV_W'(rms_reg);
                div_divisor  = DVS_W'(calls_eff);
                div_ret      = ST_CAP_DONE;
            end
            ST_OP:
            begin
                div_start    = (op_reg == OP_BUMP) && dl_nz;
                div_dividend = DIV_W'(rs_reg);
                div_divisor  = SEC_PER_MIN;
                div_ret      = ST_BUMP_W;
            end
            ST_BUMP_W:
            begin
                div_start    = !dl_past;
                div_dividend = DIV_W'(bump_num);
                div_divisor  = SEC_PER_MIN;
                div_ret      = ST_BUMP_D;
            end
            ST_PROG2:
            begin
                div_start    = !prog_fin && !rem_clamp;
                div_dividend = DIV_W'(pnum);
                div_divisor  = rms_reg;
                div_ret      = ST_P_DONE;
            end
            ST_LEVEL:
            begin
                div_start    = fade_reg;
                div_dividend = DIV_W'(lvl_num);
                div_divisor  = rms_reg;
                div_ret      = ST_L_DONE;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (div_start)
        begin
            state_next = ST_DIV_WAIT;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:     state_next = accept ? ST_PREP : ST_IDLE;
                ST_PREP:     state_next = ST_DIV_WAIT;
                ST_DIV_WAIT: state_next = div_stat.done ? ret_reg : ST_DIV_WAIT;
                ST_NS_DONE:  state_next = ST_OP;
                ST_R_DONE:   state_next = ST_OP;
                ST_CAP_DONE: state_next = ST_OP;
                ST_OP:
                begin
                    case (op_reg)
                        OP_TICK:  state_next = tick_hit ? ST_PROG : ST_FIN;
                        OP_SET:   state_next = ST_SET;
                        OP_ADD:   state_next = ST_ADD;
                        OP_SHORT: state_next = short_hit ? ST_SET : ST_FIN;
                        default:  state_next = ST_FIN;
                    endcase
                end
                ST_BUMP_W:   state_next = ST_ADD;
                ST_BUMP_D:   state_next = d_le_w ? ST_ADD : ST_FIN;
                ST_ADD:      state_next = (m_reg == '0) ? ST_FIN : ST_SET;
                ST_SET:      state_next = (t_le_now || !dl_nz) ? ST_FIN : ST_PROG;
                ST_PROG:     state_next = ST_PROG2;
                ST_PROG2:    state_next = (rem_clamp && !prog_fin && is_tick) ? ST_LEVEL : ST_FIN;
                ST_P_DONE:   state_next = is_tick ? ST_LEVEL : ST_FIN;
                ST_LEVEL:    state_next = ST_FIN;
                ST_L_DONE:   state_next = ST_FIN;
                ST_FIN:      state_next = out_free ? ST_IDLE : ST_FIN;
                default:     state_next = ST_IDLE;
            endcase
        end
    end

    // Datapath and result updates of each state.
    always_comb
    begin
        ret_next       = div_start ? div_ret : ret_reg;
        deadline_next  = deadline_reg;
        fade_next      = fade_reg;
        op_next        = op_reg;
        now_ms_next    = now_ms_reg;
        arg_next       = arg_reg;
        rs_next        = rs_reg;
        rms_next       = rms_reg;
        now_s_next     = now_s_reg;
        period_next    = period_reg;
        r_next         = r_reg;
        t_next         = t_reg;
        m_next         = m_reg;
        w_next         = w_reg;
        target_next    = target_reg;
        rem_next       = rem_reg;
        lv_next        = lv_reg;
        lim_next       = lim_reg;
        pv_next        = pv_reg;
        prog_next      = prog_reg;
        poff_next      = poff_reg;
        alert_next     = alert_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(event_ch.op);
                    now_ms_next = event_ch.now_ms;
                    arg_next    = event_ch.arg_value;
                    rs_next     = (ramp_reg == '0) ? RAMP_W'(1) : ramp_reg;
                    lv_next     = 1'b0;
                    lim_next    = '0;
                    pv_next     = 1'b0;
                    prog_next   = '0;
                    poff_next   = 1'b0;
                    alert_next  = ALERT_NONE;
                end
            end
            ST_PREP:
            begin
                rms_next = RMS_W'(RMS_W'(rs_reg) * MS_PER_S);
            end
            ST_NS_DONE:
            begin
                now_s_next = div_quo[NOW_S_W-1:0];
                if (saved_reg == '0)
                begin
                    period_next = IDLE_DELAY_MS;
                end
            end
            ST_R_DONE:
            begin
                r_next = r_plus;
                if (r_le_loop)
                begin
                    period_next = RMS_W'(loop_reg);
                end
            end
            ST_CAP_DONE:
            begin
                period_next = (r_reg < div_quo[RMS_W-1:0]) ? r_reg : div_quo[RMS_W-1:0];
            end
            ST_OP:
            begin
                t_next = (op_reg == OP_SHORT) ? nsr_sum[DEADLINE_W-1:0] : arg_reg;
                m_next = arg_reg;
                case (op_reg)
                    OP_CANCEL:
                    begin
                        deadline_next = '0;
                        fade_next     = 1'b1;
                        lv_next       = 1'b1;
                        lim_next      = full_reg;
                        alert_next    = ALERT_CLEAR;
                    end
                    OP_LOCK:
                    begin
                        fade_next = (arg_reg == '0);
                    end
                    default:
                    begin
                        fade_next = fade_reg;
                    end
                endcase
            end
            ST_BUMP_W:
            begin
                // Expired deadline: add the whole window in minutes.
                w_next = div_quo[WIN_W-1:0];
                m_next = ARG_W'(div_quo[WIN_W-1:0]);
            end
            ST_BUMP_D:
            begin
                m_next = ARG_W'(w_reg) + ARG_W'(1) - ARG_W'(div_quo[WIN_W:0]);
            end
            ST_ADD:
            begin
                t_next = t_sat;
            end
            ST_SET:
            begin
                if (!t_le_now)
                begin
                    deadline_next = t_reg;
                    lv_next       = 1'b1;
                    lim_next      = saved_reg;
                    if (!dl_nz)
                    begin
                        alert_next = ALERT_RAISE;
                    end
                end
            end
            ST_PROG:
            begin
                target_next = TARGET_W'(deadline_reg) * TARGET_W'(MS_PER_S);
            end
            ST_PROG2:
            begin
                pv_next = 1'b1;
                if (prog_fin)
                begin
                    prog_next = PROG_DONE;
                    if (is_tick)
                    begin
                        // Deadline reached: cancel, then drop the limit to zero.
                        deadline_next = '0;
                        fade_next     = 1'b1;
                        lv_next       = 1'b1;
                        lim_next      = '0;
                        alert_next    = ALERT_CLEAR;
                        poff_next     = 1'b1;
                    end
                end
                else if (rem_clamp)
                begin
                    prog_next = '0;
                    rem_next  = rms_reg;
                end
                else
                begin
                    rem_next = rem_full[RMS_W-1:0];
                end
            end
            ST_P_DONE:
            begin
                prog_next = div_quo[PROG_W-1:0];
            end
            ST_L_DONE:
            begin
                lv_next  = 1'b1;
                lim_next = div_quo[LEVEL_W-1:0];
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.level_valid    = lv_reg;
                    out_next.level_limit    = lim_reg;
                    out_next.progress_valid = pv_reg;
                    out_next.progress_q16   = prog_reg;
                    out_next.power_off      = poff_reg;
                    out_next.alert_event    = alert_reg;
                    out_next.timer_on       = dl_nz;
                    out_next.tick_delay_ms  = (period_reg > RMS_W'(DELAY_MAX)) ?
                                              DELAY_MAX : period_reg[DELAY_W-1:0];
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg   <= RAMP_W'(180);
            maxadd_reg <= MAXADD_W'(10);
            loop_reg   <= LOOP_W'(5);
            calls_reg  <= CALLS_W'(50);
            saved_reg  <= '1;
            full_reg   <= '1;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_ch.reg_index)
                CFG_RAMP:   ramp_reg   <= cfg_ch.wr_data[RAMP_W-1:0];
                CFG_MAXADD: maxadd_reg <= cfg_ch.wr_data[MAXADD_W-1:0];
                CFG_LOOP:   loop_reg   <= cfg_ch.wr_data[LOOP_W-1:0];
                CFG_CALLS:  calls_reg  <= cfg_ch.wr_data[CALLS_W-1:0];
                CFG_SAVED:  saved_reg  <= cfg_ch.wr_data[LEVEL_W-1:0];
                CFG_FULL:   full_reg   <= cfg_ch.wr_data[LEVEL_W-1:0];
                default:    ramp_reg   <= ramp_reg;
            endcase
        end
    end

    // Control registers and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            deadline_reg  <= '0;
            fade_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            deadline_reg  <= deadline_next;
            fade_reg      <= fade_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        now_ms_reg <= now_ms_next;
        arg_reg    <= arg_next;
        rs_reg     <= rs_next;
        rms_reg    <= rms_next;
        now_s_reg  <= now_s_next;
        period_reg <= period_next;
        r_reg      <= r_next;
        t_reg      <= t_next;
        m_reg      <= m_next;
        w_reg      <= w_next;
        target_reg <= target_next;
        rem_reg    <= rem_next;
        lv_reg     <= lv_next;
        lim_reg    <= lim_next;
        pv_reg     <= pv_next;
        prog_reg   <= prog_next;
        poff_reg   <= poff_next;
        alert_reg  <= alert_next;
        out_reg    <= out_next;
    end

    // Shared divider.
    stfo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Result channel.
    assign result_ch.valid          = out_valid_reg;
    assign result_ch.level_valid    = out_reg.level_valid;
    assign result_ch.level_limit    = out_reg.level_limit;
    assign result_ch.progress_valid = out_reg.progress_valid;
    assign result_ch.progress_q16   = out_reg.progress_q16;
    assign result_ch.power_off      = out_reg.power_off;
    assign result_ch.alert_event    = out_reg.alert_event;
    assign result_ch.timer_on       = out_reg.timer_on;
    assign result_ch.tick_delay_ms  = out_reg.tick_delay_ms;

`ifndef SYNTH
    // An accepted item keeps the sequencer busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !event_ch.ready)
        else $error("event channel ready right after an accepted item");

    // The divider is never restarted while a quotient is still in progress.
    a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Power-off always comes with the timer cleared, a zero limit and a cleared alert.
    a_power_off_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.power_off) |->
        (!result_ch.timer_on && result_ch.level_limit == '0 &&
         result_ch.alert_event == ALERT_CLEAR && result_ch.progress_q16 == PROG_DONE))
        else $error("power-off result with inconsistent fields");

    // Progress reads zero unless it is flagged.
    a_progress_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && !result_ch.progress_valid) |-> result_ch.progress_q16 == '0)
        else $error("progress value without its flag");
`endif

endmodule

`default_nettype wire
